>>> sv/fkpa_pkg.sv
// shared types and constants for the free key pool allocator
package fkpa_pkg;

   localparam int KEY_W      = 16;
   localparam int CFG_W      = 16;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   localparam logic REG_RANGE_LOW  = 1'b0;
   localparam logic REG_RANGE_HIGH = 1'b1;

   localparam logic [KEY_W-1:0] RESET_KEY_BOTTOM = KEY_W'(2);
   localparam logic [KEY_W-1:0] RESET_KEY_NEXT   = KEY_W'(1);
   localparam logic [CFG_W-1:0] RESET_RANGE_LOW  = CFG_W'(1);
   localparam logic [CFG_W-1:0] RESET_RANGE_HIGH = CFG_W'(2);

   typedef enum logic [1:0] {
      OP_REFILL = 2'd0,
      OP_TAKE   = 2'd1,
      OP_RETURN = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_DUP      = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_BAD      = 3'd5
   } status_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [KEY_W-1:0] granted_key;
   } rsp_type;

endpackage

>>> sv/fkpa_ram.sv
// generic single write port ram with registered read
module fkpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/fkpa_engine.sv
// sequencer with shared scan pointer and key compare for the key stack
module fkpa_engine #(
   parameter int POOL_DEPTH = 1024,
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
   localparam int CW = $clog2(POOL_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  fkpa_pkg::op_type             req_operation,
   input  logic [fkpa_pkg::KEY_W-1:0]   req_key_value,
   input  logic                         req_check_duplicate,
   input  logic [fkpa_pkg::CFG_W-1:0]   range_low,
   input  logic [fkpa_pkg::CFG_W-1:0]   range_high,
   output logic                         busy,
   output fkpa_pkg::rsp_type            rsp,
   output logic [CW-1:0]                rsp_count,
   output logic                         ram_we,
   output logic [AW-1:0]                ram_waddr,
   output logic [fkpa_pkg::KEY_W-1:0]   ram_wdata,
   output logic [AW-1:0]                ram_raddr,
   input  logic [fkpa_pkg::KEY_W-1:0]   ram_rdata
);

   typedef enum logic [7:0] {
      S_INIT0 = 8'b0000_0001,
      S_INIT1 = 8'b0000_0010,
      S_IDLE  = 8'b0000_0100,
      S_FILL  = 8'b0000_1000,
      S_TAKE  = 8'b0001_0000,
      S_SCAN  = 8'b0010_0000,
      S_SHIFT = 8'b0100_0000,
      S_PUSH  = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   fkpa_pkg::op_type             op_ff, op_in;
   logic [fkpa_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [CW-1:0]                rd_pos_ff, rd_pos_in;
   logic [fkpa_pkg::KEY_W-1:0]   fill_key_ff, fill_key_in;
   logic [CW-1:0]                fill_last_ff, fill_last_in;
   fkpa_pkg::rsp_type            rsp_ff, rsp_in;

   logic [fkpa_pkg::CFG_W-1:0]   span;
   logic                         range_bad;
   logic                         key_ok;
   logic                         issue;
   logic                         hit;

   assign span      = range_high - range_low;
   assign range_bad = (range_low == '0) || (range_high <= range_low)
                      || (32'(span) >= 32'(POOL_DEPTH));
   assign key_ok    = (req_key_value >= range_low) && (req_key_value <= range_high);
   assign issue     = idx_ff < count_ff;
   assign hit       = rd_valid_ff && (ram_rdata == key_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      rd_pos_in    = rd_pos_ff;
      fill_key_in  = fill_key_ff;
      fill_last_in = fill_last_ff;
      rsp_in       = rsp_ff;
      rsp_in.valid = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = fill_key_ff;
      ram_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         S_INIT0: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(0);
            ram_wdata = fkpa_pkg::RESET_KEY_BOTTOM;
            state_in  = S_INIT1;
         end
         S_INIT1: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(1);
            ram_wdata = fkpa_pkg::RESET_KEY_NEXT;
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            ram_raddr = AW'(count_ff - CW'(1));
            if (start) begin
               op_in                = req_operation;
               key_in               = req_key_value;
               idx_in               = '0;
               rsp_in.granted_key   = '0;
               rsp_in.status        = fkpa_pkg::ST_OK;
               case (req_operation)
                  fkpa_pkg::OP_REFILL: begin
                     if (range_bad) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = fkpa_pkg::ST_BAD;
                     end else begin
                        fill_key_in  = range_high;
                        fill_last_in = CW'(span);
                        state_in     = S_FILL;
                     end
                  end
                  fkpa_pkg::OP_TAKE: begin
                     if (count_ff == '0) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = fkpa_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_TAKE;
                     end
                  end
                  fkpa_pkg::OP_RETURN: begin
                     if (!key_ok) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = fkpa_pkg::ST_RANGE;
                     end else if (req_check_duplicate) begin
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_PUSH;
                     end
                  end
                  fkpa_pkg::OP_REMOVE: begin
                     if (!key_ok) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = fkpa_pkg::ST_RANGE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FILL: begin
            ram_we      = 1'b1;
            ram_waddr   = idx_ff[AW-1:0];
            ram_wdata   = fill_key_ff;
            idx_in      = idx_ff + CW'(1);
            fill_key_in = fill_key_ff - fkpa_pkg::KEY_W'(1);
            if (idx_ff == fill_last_ff) begin
               count_in     = idx_ff + CW'(1);
               rsp_in.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TAKE: begin
            count_in           = count_ff - CW'(1);
            rsp_in.valid       = 1'b1;
            rsp_in.granted_key = ram_rdata;
            state_in           = S_IDLE;
         end
         S_SCAN: begin
            rd_valid_in = issue;
            rd_pos_in   = idx_ff;
            idx_in      = issue ? idx_ff + CW'(1) : idx_ff;
            if (hit) begin
               if (op_ff == fkpa_pkg::OP_RETURN) begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = fkpa_pkg::ST_DUP;
                  state_in      = S_IDLE;
               end else begin
                  idx_in      = rd_pos_ff + CW'(1);
                  rd_valid_in = 1'b0;
                  state_in    = S_SHIFT;
               end
            end else if (!issue && !rd_valid_ff) begin
               if (op_ff == fkpa_pkg::OP_RETURN) begin
                  state_in = S_PUSH;
               end else begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = fkpa_pkg::ST_NOTFOUND;
                  state_in      = S_IDLE;
               end
            end
         end
         S_SHIFT: begin
            rd_valid_in = issue;
            rd_pos_in   = idx_ff;
            idx_in      = issue ? idx_ff + CW'(1) : idx_ff;
            if (rd_valid_ff) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(rd_pos_ff - CW'(1));
               ram_wdata = ram_rdata;
            end else if (!issue) begin
               count_in     = count_ff - CW'(1);
               rsp_in.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_PUSH: begin
            rsp_in.valid = 1'b1;
            state_in     = S_IDLE;
            if (32'(count_ff) >= 32'(POOL_DEPTH)) begin
               rsp_in.status = fkpa_pkg::ST_BAD;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[AW-1:0];
               ram_wdata = key_ff;
               count_in  = count_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT0;
         count_ff    <= CW'(2);
         rd_valid_ff <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      rd_pos_ff    <= rd_pos_in;
      fill_key_ff  <= fill_key_in;
      fill_last_ff <= fill_last_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp       = rsp_ff;
   assign rsp_count = count_ff;

endmodule

>>> sv/free_key_pool_allocator_core.sv
// free key pool allocator: register port, key stack ram and sequencer
// An operation is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle on rsp_strobe, and it must be taken then. A refill writes one key
// to the ram a cycle; a bad range, a take on an empty pool and a range error on return
// or remove are answered straight from idle without entering another state. The
// duplicate check on return and the search for remove run through the stack up to the
// match, and the order-keeping shift for remove carries on from there, one stack
// entry a cycle through the single read and write port of the key ram. Busy stays high
// after reset while the two reset keys are loaded.
module free_key_pool_allocator_core #(
   parameter int POOL_DEPTH = 1024,
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
   localparam int CW = $clog2(POOL_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic [fkpa_pkg::KEY_W-1:0]        req_key_value,
   input  logic                              req_check_duplicate,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_status,
   output logic [fkpa_pkg::KEY_W-1:0]        rsp_granted_key,
   output logic [CW-1:0]                     rsp_free_count,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fkpa_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [fkpa_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [fkpa_pkg::APB_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic [fkpa_pkg::CFG_W-1:0]  range_low_ff, range_low_in;
   logic [fkpa_pkg::CFG_W-1:0]  range_high_ff, range_high_in;
   logic                        csr_write;
   logic                        csr_index;

   fkpa_pkg::rsp_type           rsp;
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [fkpa_pkg::KEY_W-1:0]  ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [fkpa_pkg::KEY_W-1:0]  ram_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_write) begin
         if (csr_index == fkpa_pkg::REG_RANGE_LOW) begin
            range_low_in = pwdata[fkpa_pkg::CFG_W-1:0];
         end else begin
            range_high_in = pwdata[fkpa_pkg::CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= fkpa_pkg::RESET_RANGE_LOW;
         range_high_ff <= fkpa_pkg::RESET_RANGE_HIGH;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   assign prdata = (csr_index == fkpa_pkg::REG_RANGE_HIGH)
                   ? fkpa_pkg::APB_DATA_W'(range_high_ff)
                   : fkpa_pkg::APB_DATA_W'(range_low_ff);

   fkpa_engine #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_operation       (fkpa_pkg::op_type'(req_operation)),
      .req_key_value       (req_key_value),
      .req_check_duplicate (req_check_duplicate),
      .range_low           (range_low_ff),
      .range_high          (range_high_ff),
      .busy                (busy),
      .rsp                 (rsp),
      .rsp_count           (rsp_free_count),
      .ram_we              (ram_we),
      .ram_waddr           (ram_waddr),
      .ram_wdata           (ram_wdata),
      .ram_raddr           (ram_raddr),
      .ram_rdata           (ram_rdata)
   );

   fkpa_ram #(
      .WIDTH (fkpa_pkg::KEY_W),
      .DEPTH (POOL_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_strobe      = rsp.valid;
   assign rsp_status      = rsp.status;
   assign rsp_granted_key = rsp.granted_key;

`ifndef SYNTHESIS
   a_rsp_follows_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("result without a transaction in flight");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == fkpa_pkg::ST_EMPTY)) |-> (rsp_free_count == '0))
      else $error("empty status with keys still held");

   a_grant_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != fkpa_pkg::ST_OK)) |-> (rsp_granted_key == '0))
      else $error("granted key on a failed transaction");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_free_count) <= 32'(POOL_DEPTH)))
      else $error("free count beyond pool depth");
`endif

endmodule

>>> bench/fkpa_result_checker.sv
`timescale 1ns / 100ps
// channel monitor for the free key pool allocator: predicts every result and compares it
module fkpa_result_checker #(
   parameter int POOL_DEPTH = 1024,
   localparam int FREE_W = $clog2(POOL_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [fkpa_pkg::KEY_W-1:0]      req_key_value,
   input  logic                            req_check_duplicate,
   input  logic                            rsp_strobe,
   input  logic [2:0]                      rsp_status,
   input  logic [fkpa_pkg::KEY_W-1:0]      rsp_granted_key,
   input  logic [FREE_W-1:0]               rsp_free_count,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fkpa_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [fkpa_pkg::APB_DATA_W-1:0] pwdata,
   input  logic [fkpa_pkg::APB_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              mismatches,
   output int                              pending,
   output int                              compared
);

   typedef struct packed {
      fkpa_pkg::status_type         status;
      logic [fkpa_pkg::KEY_W-1:0]   granted;
      logic [FREE_W-1:0]            free;
   } pool_result_type;

   logic [fkpa_pkg::KEY_W-1:0] pool_keys [POOL_DEPTH];
   int                         held;
   logic [fkpa_pkg::CFG_W-1:0] range_lo;
   logic [fkpa_pkg::CFG_W-1:0] range_hi;
   pool_result_type            awaited [$];

   task automatic report_mismatch(string what, longint unsigned seen, longint unsigned wanted);
      $display("%0t: %s wrong: got %0d, expected %0d", $time, what, seen, wanted);
      mismatches++;
   endtask

   task automatic load_reset_state();
      int i;
      for (i = 0; i < POOL_DEPTH; i++) pool_keys[i] = '0;
      pool_keys[0] = fkpa_pkg::RESET_KEY_BOTTOM;
      pool_keys[1] = fkpa_pkg::RESET_KEY_NEXT;
      held = 2;
      range_lo = fkpa_pkg::RESET_RANGE_LOW;
      range_hi = fkpa_pkg::RESET_RANGE_HIGH;
      awaited.delete();
   endtask

   function automatic bit key_in_range(logic [fkpa_pkg::KEY_W-1:0] key);
      return key >= range_lo && key <= range_hi;
   endfunction

   // position of the first match from the bottom, held when absent
   function automatic int locate_key(logic [fkpa_pkg::KEY_W-1:0] key);
      int i;
      for (i = 0; i < held; i++) begin
         if (pool_keys[i] == key) return i;
      end
      return held;
   endfunction

   function automatic pool_result_type apply_operation(fkpa_pkg::op_type op,
                                                       logic [fkpa_pkg::KEY_W-1:0] key,
                                                       logic chk);
      pool_result_type res;
      int              span;
      int              pos;
      int              i;
      res.status  = fkpa_pkg::ST_OK;
      res.granted = '0;
      case (op)
         fkpa_pkg::OP_REFILL: begin
            span = int'(range_hi) - int'(range_lo) + 1;
            if (range_lo == 0 || range_hi <= range_lo || span > POOL_DEPTH) begin
               res.status = fkpa_pkg::ST_BAD;
            end else begin
               for (i = 0; i < span; i++) pool_keys[i] = range_hi - fkpa_pkg::KEY_W'(i);
               held = span;
            end
         end
         fkpa_pkg::OP_TAKE: begin
            if (held == 0) begin
               res.status = fkpa_pkg::ST_EMPTY;
            end else begin
               held--;
               res.granted = pool_keys[held];
            end
         end
         fkpa_pkg::OP_RETURN: begin
            if (!key_in_range(key)) res.status = fkpa_pkg::ST_RANGE;
            else if (chk && locate_key(key) < held) res.status = fkpa_pkg::ST_DUP;
            else if (held >= POOL_DEPTH) res.status = fkpa_pkg::ST_BAD;
            else begin
               pool_keys[held] = key;
               held++;
            end
         end
         default: begin
            if (!key_in_range(key)) begin
               res.status = fkpa_pkg::ST_RANGE;
            end else begin
               pos = locate_key(key);
               if (pos >= held) begin
                  res.status = fkpa_pkg::ST_NOTFOUND;
               end else begin
                  for (i = pos; i + 1 < held; i++) pool_keys[i] = pool_keys[i + 1];
                  held--;
               end
            end
         end
      endcase
      res.free = FREE_W'(held);
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      pool_result_type            want;
      pool_result_type            fresh;
      logic [fkpa_pkg::CFG_W-1:0] reg_value;
      if (reset) begin
         load_reset_state();
         mismatches = 0;
         compared   = 0;
         pending   <= 0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (awaited.size() == 0) begin
               report_mismatch("result with nothing outstanding, status", rsp_status, 0);
            end else begin
               want = awaited.pop_front();
               compared++;
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_granted_key !== want.granted)
                  report_mismatch("granted key", rsp_granted_key, want.granted);
               if (rsp_free_count !== want.free)
                  report_mismatch("free count", rsp_free_count, want.free);
            end
         end
         if (start && !busy) begin
            fresh = apply_operation(fkpa_pkg::op_type'(req_operation), req_key_value,
                                    req_check_duplicate);
            awaited = {awaited, fresh};
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[fkpa_pkg::APB_ADDR_W-1:2] == fkpa_pkg::REG_RANGE_LOW)
                  range_lo = pwdata[fkpa_pkg::CFG_W-1:0];
               else range_hi = pwdata[fkpa_pkg::CFG_W-1:0];
            end else begin
               reg_value = (paddr[fkpa_pkg::APB_ADDR_W-1:2] == fkpa_pkg::REG_RANGE_LOW)
                           ? range_lo : range_hi;
               if (prdata !== fkpa_pkg::APB_DATA_W'(reg_value))
                  report_mismatch("register read", prdata, reg_value);
            end
         end
         pending <= awaited.size();
      end
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// stimulus, watchdog and verdict for the free key pool allocator
module tb;

   localparam int POOL_DEPTH   = 1024;
   localparam int FREE_W       = $clog2(POOL_DEPTH + 1);
   localparam int RANDOM_ITEMS = 535;
   localparam int STALL_LIMIT  = 20000;
   localparam logic [fkpa_pkg::APB_ADDR_W-1:0] ADDR_RANGE_LOW  =
      {fkpa_pkg::REG_RANGE_LOW, 2'b00};
   localparam logic [fkpa_pkg::APB_ADDR_W-1:0] ADDR_RANGE_HIGH =
      {fkpa_pkg::REG_RANGE_HIGH, 2'b00};

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_operation;
   logic [fkpa_pkg::KEY_W-1:0]      req_key_value;
   logic                            req_check_duplicate;
   logic                            rsp_strobe;
   logic [2:0]                      rsp_status;
   logic [fkpa_pkg::KEY_W-1:0]      rsp_granted_key;
   logic [FREE_W-1:0]               rsp_free_count;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [fkpa_pkg::APB_ADDR_W-1:0] paddr;
   logic [fkpa_pkg::APB_DATA_W-1:0] pwdata;
   logic [fkpa_pkg::APB_DATA_W-1:0] prdata;
   logic                            pready;

   int mismatches;
   int pending;
   int compared;
   int issued;
   int settings;
   int random_issued;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   free_key_pool_allocator_core #(.POOL_DEPTH(POOL_DEPTH)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_key_value       (req_key_value),
      .req_check_duplicate (req_check_duplicate),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted_key     (rsp_granted_key),
      .rsp_free_count      (rsp_free_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   fkpa_result_checker #(.POOL_DEPTH(POOL_DEPTH)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_key_value       (req_key_value),
      .req_check_duplicate (req_check_duplicate),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted_key     (rsp_granted_key),
      .rsp_free_count      (rsp_free_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready),
      .mismatches          (mismatches),
      .pending             (pending),
      .compared            (compared)
   );

   task automatic issue(fkpa_pkg::op_type op, logic [fkpa_pkg::KEY_W-1:0] key, logic chk);
      req_operation       <= op;
      req_key_value       <= key;
      req_check_duplicate <= chk;
      start               <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // write then read back, so every register access is seen by the monitor
   task automatic write_reg(logic [fkpa_pkg::APB_ADDR_W-1:0] addr,
                            logic [fkpa_pkg::CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {16'($urandom_range(16'hFFFF)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic set_range(int lo, int hi);
      write_reg(ADDR_RANGE_LOW, fkpa_pkg::CFG_W'(lo));
      write_reg(ADDR_RANGE_HIGH, fkpa_pkg::CFG_W'(hi));
      psel    <= 1'b0;
      penable <= 1'b0;
      settings++;
   endtask

   function automatic logic [fkpa_pkg::KEY_W-1:0] pick_key(int lo, int hi);
      int k;
      if ($urandom_range(99) < 85) begin
         k = $urandom_range(hi + 1, (lo > 0) ? lo - 1 : 0);
         if (k > 65535) k = 65535;
      end else begin
         k = $urandom_range(65535);
      end
      return fkpa_pkg::KEY_W'(k);
   endfunction

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe || (psel && penable) || reset) quiet = 0;
         else quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int  lo;
      int  hi;
      int  burst;
      int  kind;
      int  phase;
      int  pick;
      int  n;
      bit  steady;
      issued        = 0;
      settings      = 0;
      random_issued = 0;
      reset               <= 1'b1;
      start               <= 1'b0;
      req_operation       <= fkpa_pkg::OP_REFILL;
      req_key_value       <= '0;
      req_check_duplicate <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset pool holds 2 then 1
      issue(fkpa_pkg::OP_TAKE, 16'hFFFF, 1'b1);
      issue(fkpa_pkg::OP_TAKE, 16'h0000, 1'b0);
      issue(fkpa_pkg::OP_TAKE, 16'h0000, 1'b0);
      issue(fkpa_pkg::OP_RETURN, 16'd0, 1'b0);
      issue(fkpa_pkg::OP_RETURN, 16'd3, 1'b1);
      issue(fkpa_pkg::OP_RETURN, 16'd2, 1'b1);
      issue(fkpa_pkg::OP_RETURN, 16'd2, 1'b1);
      issue(fkpa_pkg::OP_RETURN, 16'd2, 1'b0);
      issue(fkpa_pkg::OP_RETURN, 16'd1, 1'b0);
      issue(fkpa_pkg::OP_REMOVE, 16'd2, 1'b0);
      issue(fkpa_pkg::OP_REMOVE, 16'hFFFF, 1'b0);
      issue(fkpa_pkg::OP_REMOVE, 16'd1, 1'b1);
      issue(fkpa_pkg::OP_REMOVE, 16'd1, 1'b0);
      issue(fkpa_pkg::OP_REFILL, 16'h5A5A, 1'b1);
      drain();

      // bad refill ranges leave the pool alone
      set_range(0, 9);
      issue(fkpa_pkg::OP_REFILL, '0, 1'b0);
      drain();
      set_range(5, 5);
      issue(fkpa_pkg::OP_REFILL, '0, 1'b0);
      drain();
      set_range(9, 4);
      issue(fkpa_pkg::OP_REFILL, '0, 1'b0);
      drain();
      set_range(1, POOL_DEPTH + 1);
      issue(fkpa_pkg::OP_REFILL, '0, 1'b0);
      drain();

      // full pool
      set_range(1, POOL_DEPTH);
      issue(fkpa_pkg::OP_REFILL, '0, 1'b0);
      issue(fkpa_pkg::OP_RETURN, 16'd7, 1'b0);
      issue(fkpa_pkg::OP_RETURN, 16'd7, 1'b1);
      issue(fkpa_pkg::OP_TAKE, '0, 1'b0);
      issue(fkpa_pkg::OP_REMOVE, 16'(POOL_DEPTH), 1'b0);
      issue(fkpa_pkg::OP_RETURN, 16'd1, 1'b1);
      drain();
      set_range(65536 - POOL_DEPTH, 65535);
      issue(fkpa_pkg::OP_REFILL, '0, 1'b0);
      issue(fkpa_pkg::OP_TAKE, '0, 1'b0);
      drain();

      phase = 0;
      while (random_issued < RANDOM_ITEMS) begin
         kind = $urandom_range(99);
         if (phase == 0) begin
            lo = 65534;
            hi = 65535;
            burst = 20;
         end else if (phase == 1) begin
            lo = 0;
            hi = 30;
            burst = 25;
         end else if (kind < 8) begin
            lo = $urandom_range(1, 65536 - POOL_DEPTH);
            hi = lo + POOL_DEPTH - 1 - $urandom_range(3);
            burst = 10;
         end else if (kind < 16) begin
            lo = $urandom_range(65535);
            hi = $urandom_range(65535);
            burst = 15;
         end else begin
            lo = $urandom_range(1, 65500);
            hi = lo + $urandom_range(1, 40);
            burst = 30;
         end
         set_range(lo, hi);
         issue(fkpa_pkg::OP_REFILL, fkpa_pkg::KEY_W'($urandom_range(65535)),
               1'($urandom_range(1)));
         for (n = 0; n < burst && random_issued < RANDOM_ITEMS; n++) begin
            steady = random_issued >= 200 && random_issued < 320;
            if (!steady && $urandom_range(99) < 11) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end else if (!steady && $urandom_range(99) < 3) begin
               drain();
            end
            pick = $urandom_range(99);
            if (pick < 30)
               issue(fkpa_pkg::OP_TAKE, fkpa_pkg::KEY_W'($urandom_range(65535)),
                     1'($urandom_range(1)));
            else if (pick < 60)
               issue(fkpa_pkg::OP_RETURN, pick_key(lo, hi), 1'($urandom_range(1)));
            else if (pick < 88)
               issue(fkpa_pkg::OP_REMOVE, pick_key(lo, hi), 1'($urandom_range(1)));
            else if (pick < 94)
               issue(fkpa_pkg::OP_REFILL, fkpa_pkg::KEY_W'($urandom_range(65535)), 1'b0);
            else
               issue(fkpa_pkg::op_type'($urandom_range(3)),
                     fkpa_pkg::KEY_W'($urandom_range(65535)), 1'($urandom_range(1)));
            random_issued++;
         end
         drain();
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      $display("summary: %0d operations over %0d range settings, %0d results compared",
               issued, settings, compared);
      $display("covered empty, full, duplicate, not-found, out-of-range and bad-range cases");
      if (mismatches == 0 && pending == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
